>>> src/bpc_pkg.sv
// Package for the barometer pressure compensation block.
// Word types, divider tag bundles, config indexes and fixed constants.
// No dependencies.
package bpc_pkg;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [18:0] raw_pressure;
  } in_word_t;

  typedef struct packed {
    logic signed [11:0] temperature_tenths;
    logic [16:0]        pressure_pa;
    logic               divide_fault;
  } out_word_t;

  localparam logic [1:0] CFG_CAL_A = 2'd0;
  localparam logic [1:0] CFG_CAL_B = 2'd1;
  localparam logic [1:0] CFG_CAL_C = 2'd2;
  localparam logic [1:0] CFG_OSS   = 2'd3;

  localparam int T_NUM_W = 27;
  localparam int T_DEN_W = 18;
  localparam int P_NUM_W = 32;
  localparam int P_DEN_W = 32;

  localparam int TEMP_OFFSET = 4000;
  localparam int B4_BIAS     = 32768;
  localparam int PRES_SCALE  = 50000;
  localparam int CORR_SQ     = 3038;
  localparam int CORR_LIN    = -7357;
  localparam int CORR_OFS    = 3791;
  localparam int TEMP_MIN    = -2048;
  localparam int TEMP_MAX    = 2047;
  localparam int PRES_MAX    = 131071;

  typedef struct packed {
    logic signed [17:0] x1;
    logic               neg;
    logic               zero;
    logic [18:0]        up;
  } div1_tag_t;

  typedef struct packed {
    logic signed [11:0] temp;
    logic               fault;
    logic               hi;
    logic               zero;
  } div2_tag_t;

endpackage

>>> src/bpc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Unsigned operands; a side tag travels with each word. Uses no package.
module bpc_div #(
  parameter int NW = 27,
  parameter int DW = 18,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [TW-1:0] tag_in,
  output logic          out_valid,
  output logic [NW-1:0] quotient,
  output logic [TW-1:0] tag_out
);

  logic          vld [NW];
  logic [DW-1:0] rem [NW];
  logic [NW-1:0] num [NW];
  logic [DW-1:0] den [NW];
  logic [TW-1:0] tag [NW];

  logic          pv_vld [NW];
  logic [DW-1:0] pv_rem [NW];
  logic [NW-1:0] pv_num [NW];
  logic [DW-1:0] pv_den [NW];
  logic [TW-1:0] pv_tag [NW];

  always_comb begin
    pv_vld[0] = in_valid;
    pv_rem[0] = '0;
    pv_num[0] = dividend;
    pv_den[0] = divisor;
    pv_tag[0] = tag_in;
    for (int k = 1; k < NW; k++) begin
      pv_vld[k] = vld[k-1];
      pv_rem[k] = rem[k-1];
      pv_num[k] = num[k-1];
      pv_den[k] = den[k-1];
      pv_tag[k] = tag[k-1];
    end
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb begin
      trial = {pv_rem[k], pv_num[k][NW-1]};
      diff  = trial - {1'b0, pv_den[k]};
      ge    = trial >= {1'b0, pv_den[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= pv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      num[k] <= {pv_num[k][NW-2:0], ge};
      den[k] <= pv_den[k];
      tag[k] <= pv_tag[k];
    end
  end

  assign out_valid = vld[NW-1];
  assign quotient  = num[NW-1];
  assign tag_out   = tag[NW-1];

endmodule

>>> src/barometer_pressure_compensation.sv
// Barometer pressure compensation, top level. Uses bpc_pkg and bpc_div.
// The datapath is fully pipelined around two dividers that produce one quotient
// bit per stage, with 27 and 32 stages.
// Throughput: one word per cycle; busy stays low and the receiver cannot stall.
// Reset clears calibration registers and all stage valid bits.
module barometer_pressure_compensation (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bpc_pkg::in_word_t sample,
  output logic              done,
  output bpc_pkg::out_word_t result,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import bpc_pkg::*;

  logic [63:0] cal_word_a;
  logic [63:0] cal_word_b;
  logic [31:0] cal_word_c;
  logic [1:0]  oversampling;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_word_a   <= '0;
      cal_word_b   <= '0;
      cal_word_c   <= '0;
      oversampling <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CAL_A: cal_word_a   <= cfg_data;
        CFG_CAL_B: cal_word_b   <= cfg_data;
        CFG_CAL_C: cal_word_c   <= cfg_data[31:0];
        CFG_OSS:   oversampling <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;
  assign ac1 = cal_word_a[63:48];
  assign ac2 = cal_word_a[47:32];
  assign ac3 = cal_word_a[31:16];
  assign ac4 = cal_word_a[15:0];
  assign ac5 = cal_word_b[63:48];
  assign ac6 = cal_word_b[47:32];
  assign b1  = cal_word_b[31:16];
  assign b2  = cal_word_b[15:0];
  assign mc  = cal_word_c[31:16];
  assign md  = cal_word_c[15:0];

  assign busy = 1'b0;

  // stage valids
  logic a_vld, b_vld, c_vld, d_vld, e_vld, f_vld, g_vld, h_vld, i_vld;
  logic j_vld, k_vld, l_vld, m_vld, n_vld, p_vld, q_vld, r_vld, s_vld;
  logic dv1_vld, dv2_vld;

  // stage data
  logic [15:0]        a_ut;
  logic [18:0]        a_up;
  logic signed [34:0] b_m1;
  logic [18:0]        b_up;
  logic signed [17:0] c_x1;
  logic signed [18:0] c_den;
  logic signed [26:0] c_num;
  logic [18:0]        c_up;
  logic [T_NUM_W-1:0] d_nmag;
  logic [T_DEN_W-1:0] d_dmag;
  div1_tag_t          d_tag;
  logic [T_NUM_W-1:0] dv1_q;
  logic [$bits(div1_tag_t)-1:0] dv1_tag_bits;
  div1_tag_t          dv1_tag;
  logic signed [28:0] e_b5;
  logic               e_fault;
  logic [18:0]        e_up;
  logic [59:0]        f_sq;
  logic signed [45:0] f_pa2, f_pa3;
  logic signed [11:0] f_temp;
  logic               f_fault;
  logic [18:0]        f_up;
  logic signed [39:0] g_b2lo, g_b2hi, g_b1lo, g_b1hi;
  logic signed [45:0] g_a2s, g_a3s;
  logic signed [11:0] g_temp;
  logic               g_fault;
  logic [18:0]        g_up;
  logic signed [63:0] h_bsq2, h_bsq1;
  logic signed [45:0] h_a2s, h_a3s;
  logic signed [11:0] h_temp;
  logic               h_fault;
  logic [18:0]        h_up;
  logic signed [63:0] i_x3a, i_x3b;
  logic signed [11:0] i_temp;
  logic               i_fault;
  logic [18:0]        i_up;
  logic signed [63:0] j_num3;
  logic [31:0]        j_u;
  logic signed [11:0] j_temp;
  logic               j_fault;
  logic [18:0]        j_up;
  logic [31:0]        k_b3;
  logic [47:0]        k_b4m;
  logic signed [11:0] k_temp;
  logic               k_fault;
  logic [18:0]        k_up;
  logic [31:0]        l_b4, l_diff;
  logic signed [11:0] l_temp;
  logic               l_fault;
  logic [31:0]        m_b7, m_b4;
  logic signed [11:0] m_temp;
  logic               m_fault;
  logic [P_NUM_W-1:0] n_num;
  logic [P_DEN_W-1:0] n_den;
  div2_tag_t          n_tag;
  logic [P_NUM_W-1:0] dv2_q;
  logic [$bits(div2_tag_t)-1:0] dv2_tag_bits;
  div2_tag_t          dv2_tag;
  logic [31:0]        p_q;
  logic signed [11:0] p_temp;
  logic               p_fault;
  logic [47:0]        q_sqp;
  logic signed [47:0] q_m7;
  logic [31:0]        q_q;
  logic signed [11:0] q_temp;
  logic               q_fault;
  logic [59:0]        r_m3038;
  logic signed [47:0] r_x2p;
  logic [31:0]        r_q;
  logic signed [11:0] r_temp;
  logic               r_fault;
  logic signed [47:0] s_p;
  logic signed [11:0] s_temp;
  logic               s_fault;

  // combinational helpers
  logic signed [17:0] b_diff;
  logic signed [34:0] b_prod;
  logic signed [26:0] d_num_neg;
  logic signed [18:0] d_den_neg;
  logic signed [27:0] e_x2;
  logic signed [29:0] f_b6;
  logic signed [29:0] f_tsum;
  logic signed [25:0] f_tsh;
  logic [45:0]        g_sq;
  logic signed [23:0] g_lo, g_hi;
  logic signed [63:0] j_ac1x4;
  logic signed [63:0] j_sum;
  logic signed [63:0] k_b3w;
  logic [47:0]        m_prod;
  logic [15:0]        m_scale;
  logic signed [47:0] s_corr;
  logic signed [47:0] t_p;

  assign b_diff    = $signed({2'b00, a_ut}) - $signed({2'b00, ac6});
  assign b_prod    = 35'(b_diff) * 35'($signed({1'b0, ac5}));
  assign d_num_neg = -c_num;
  assign d_den_neg = -c_den;
  assign e_x2      = dv1_tag.zero ? 28'sd0 :
                     dv1_tag.neg ? -$signed({1'b0, dv1_q}) : $signed({1'b0, dv1_q});
  assign f_b6      = 30'(e_b5) - 30'(TEMP_OFFSET);
  assign f_tsum    = 30'(e_b5) + 30'sd8;
  assign f_tsh     = 26'(f_tsum >>> 4);
  assign g_sq      = f_sq[57:12];
  assign g_lo      = $signed({1'b0, g_sq[22:0]});
  assign g_hi      = $signed({1'b0, g_sq[45:23]});
  assign j_ac1x4   = 64'(ac1) <<< 2;
  assign j_sum     = j_ac1x4 + i_x3a;
  assign k_b3w     = j_num3[63] ? ((j_num3 + 64'sd3) >>> 2) : (j_num3 >>> 2);
  assign m_scale   = 16'(PRES_SCALE) >> oversampling;
  assign m_prod    = 48'(l_diff) * 48'(m_scale);
  assign s_corr    = ($signed({4'b0000, r_m3038[59:16]}) + r_x2p + 48'(CORR_OFS)) >>> 4;
  assign t_p       = s_p;

  assign dv1_tag   = div1_tag_t'(dv1_tag_bits);
  assign dv2_tag   = div2_tag_t'(dv2_tag_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0; b_vld <= 1'b0; c_vld <= 1'b0; d_vld <= 1'b0;
      e_vld <= 1'b0; f_vld <= 1'b0; g_vld <= 1'b0; h_vld <= 1'b0;
      i_vld <= 1'b0; j_vld <= 1'b0; k_vld <= 1'b0; l_vld <= 1'b0;
      m_vld <= 1'b0; n_vld <= 1'b0; p_vld <= 1'b0; q_vld <= 1'b0;
      r_vld <= 1'b0; s_vld <= 1'b0; done  <= 1'b0;
    end else begin
      a_vld <= start & ~busy;
      b_vld <= a_vld;  c_vld <= b_vld;  d_vld <= c_vld;
      e_vld <= dv1_vld; f_vld <= e_vld; g_vld <= f_vld; h_vld <= g_vld;
      i_vld <= h_vld;  j_vld <= i_vld;  k_vld <= j_vld; l_vld <= k_vld;
      m_vld <= l_vld;  n_vld <= m_vld;
      p_vld <= dv2_vld; q_vld <= p_vld; r_vld <= q_vld; s_vld <= r_vld;
      done  <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_ut <= sample.raw_temperature;
    a_up <= sample.raw_pressure;

    b_m1 <= b_prod;
    b_up <= a_up;

    c_x1  <= 18'(b_m1 >>> 15);
    c_den <= 19'(18'(b_m1 >>> 15)) + 19'(md);
    c_num <= {mc, 11'b0};
    c_up  <= b_up;

    d_nmag     <= c_num[26] ? T_NUM_W'(d_num_neg) : T_NUM_W'(c_num);
    d_dmag     <= c_den[18] ? T_DEN_W'(d_den_neg) : T_DEN_W'(c_den);
    d_tag.x1   <= c_x1;
    d_tag.neg  <= c_num[26] ^ c_den[18];
    d_tag.zero <= c_den == 19'sd0;
    d_tag.up   <= c_up;

    e_b5    <= 29'(dv1_tag.x1) + 29'(e_x2);
    e_fault <= dv1_tag.zero;
    e_up    <= dv1_tag.up;

    f_sq  <= 60'(f_b6 * f_b6);
    f_pa2 <= 46'(ac2) * 46'(f_b6);
    f_pa3 <= 46'(ac3) * 46'(f_b6);
    if (f_tsh < 26'(TEMP_MIN)) begin
      f_temp <= 12'(TEMP_MIN);
    end else if (f_tsh > 26'(TEMP_MAX)) begin
      f_temp <= 12'(TEMP_MAX);
    end else begin
      f_temp <= 12'(f_tsh);
    end
    f_fault <= e_fault;
    f_up    <= e_up;

    g_b2lo  <= 40'(b2) * 40'(g_lo);
    g_b2hi  <= 40'(b2) * 40'(g_hi);
    g_b1lo  <= 40'(b1) * 40'(g_lo);
    g_b1hi  <= 40'(b1) * 40'(g_hi);
    g_a2s   <= f_pa2 >>> 11;
    g_a3s   <= f_pa3 >>> 13;
    g_temp  <= f_temp;
    g_fault <= f_fault;
    g_up    <= f_up;

    h_bsq2  <= (64'(g_b2hi) <<< 23) + 64'(g_b2lo);
    h_bsq1  <= (64'(g_b1hi) <<< 23) + 64'(g_b1lo);
    h_a2s   <= g_a2s;
    h_a3s   <= g_a3s;
    h_temp  <= g_temp;
    h_fault <= g_fault;
    h_up    <= g_up;

    i_x3a   <= (h_bsq2 >>> 11) + 64'(h_a2s);
    i_x3b   <= (64'(h_a3s) + (h_bsq1 >>> 16) + 64'sd2) >>> 2;
    i_temp  <= h_temp;
    i_fault <= h_fault;
    i_up    <= h_up;

    j_num3  <= (j_sum <<< oversampling) + 64'sd2;
    j_u     <= i_x3b[31:0] + 32'(B4_BIAS);
    j_temp  <= i_temp;
    j_fault <= i_fault;
    j_up    <= i_up;

    k_b3    <= k_b3w[31:0];
    k_b4m   <= 48'(ac4) * 48'(j_u);
    k_temp  <= j_temp;
    k_fault <= j_fault;
    k_up    <= j_up;

    l_b4    <= k_b4m[46:15];
    l_diff  <= {13'b0, k_up} - k_b3;
    l_temp  <= k_temp;
    l_fault <= k_fault;

    m_b7    <= m_prod[31:0];
    m_b4    <= l_b4;
    m_temp  <= l_temp;
    m_fault <= l_fault;

    n_num       <= m_b7[31] ? m_b7 : {m_b7[30:0], 1'b0};
    n_den       <= m_b4;
    n_tag.temp  <= m_temp;
    n_tag.fault <= m_fault;
    n_tag.hi    <= m_b7[31];
    n_tag.zero  <= m_b4 == 32'd0;

    p_q     <= dv2_tag.zero ? 32'd0 : (dv2_tag.hi ? {dv2_q[30:0], 1'b0} : dv2_q);
    p_temp  <= dv2_tag.temp;
    p_fault <= dv2_tag.fault | dv2_tag.zero;

    q_sqp   <= 48'(p_q[31:8]) * 48'(p_q[31:8]);
    q_m7    <= 48'(CORR_LIN) * $signed({16'b0, p_q});
    q_q     <= p_q;
    q_temp  <= p_temp;
    q_fault <= p_fault;

    r_m3038 <= 60'(q_sqp) * 60'(CORR_SQ);
    r_x2p   <= q_m7 >>> 16;
    r_q     <= q_q;
    r_temp  <= q_temp;
    r_fault <= q_fault;

    s_p     <= $signed({16'b0, r_q}) + s_corr;
    s_temp  <= r_temp;
    s_fault <= r_fault;

    result.temperature_tenths <= s_temp;
    result.divide_fault       <= s_fault;
    if (t_p < 48'sd0) begin
      result.pressure_pa <= 17'd0;
    end else if (t_p > 48'(PRES_MAX)) begin
      result.pressure_pa <= 17'(PRES_MAX);
    end else begin
      result.pressure_pa <= t_p[16:0];
    end
  end

  bpc_div #(
    .NW(T_NUM_W),
    .DW(T_DEN_W),
    .TW($bits(div1_tag_t))
  ) u_div_temp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_vld),
    .dividend (d_nmag),
    .divisor  (d_dmag),
    .tag_in   (d_tag),
    .out_valid(dv1_vld),
    .quotient (dv1_q),
    .tag_out  (dv1_tag_bits)
  );

  bpc_div #(
    .NW(P_NUM_W),
    .DW(P_DEN_W),
    .TW($bits(div2_tag_t))
  ) u_div_pres (
    .clk      (clk),
    .rst      (rst),
    .in_valid (n_vld),
    .dividend (n_num),
    .divisor  (n_den),
    .tag_in   (n_tag),
    .out_valid(dv2_vld),
    .quotient (dv2_q),
    .tag_out  (dv2_tag_bits)
  );

endmodule
